[design/mrs_pkg.sv]
// ----------------------------------------------------------------------------
// mrs_pkg: shared types and constants for the Modbus RTU register slave.
// Holds the request action codes, the sequencer states and the CRC step.
// ----------------------------------------------------------------------------
package mrs_pkg;

    typedef enum logic [1:0] {
        ACT_BYTE  = 2'd0,
        ACT_END   = 2'd1,
        ACT_WHOLD = 2'd2,
        ACT_WINP  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_HDR,
        ST_RDREQ,
        ST_RDWAIT,
        ST_DATA,
        ST_CRC,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  EXC_FLAG   = 8'h80;
    localparam logic [7:0]  EXC_QTY    = 8'h03;
    localparam logic [7:0]  EXC_RANGE  = 8'h02;
    localparam logic [7:0]  FC_HOLDING = 8'h03;
    localparam logic [7:0]  FC_INPUT   = 8'h04;

    localparam int unsigned REG_SLAVE_ID      = 0;
    localparam int unsigned REG_HOLDING_COUNT = 1;
    localparam int unsigned REG_INPUT_COUNT   = 2;
    localparam int unsigned REG_INPUT_BASE    = 3;

    // One byte through the reflected CRC-16 (eight narrow shift steps).
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[design/mrs_store.sv]
// ----------------------------------------------------------------------------
// mrs_store: one register store, a synchronous simple dual-port memory with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module mrs_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);
    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[design/modbus_rtu_register_slave.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave: Modbus RTU slave for read holding and read input
// registers.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (in_valid / in_stall). Each request is a
// received byte, a frame end silence mark, or a write of one holding or input
// register. Response bytes leave on the out channel (out_valid / out_stall)
// in groups of up to four, first byte in tx_data[31:24], with tx_last on the
// final group of a frame.
// A received byte or a store write is taken without holding the input. A
// frame end that gets no answer holds the input while the frame is judged.
// A frame end with an answer holds it while the reply is built: for each
// register read the sequencer issues the read request, waits on the
// registered read of the store memory (one read a word), then sends the
// high byte and the low byte. Only one request is in work at a time;
// in_stall is high while a reply is being built or while its groups wait
// on out_stall.
// A stalled group simply holds; the sequencer waits only to close the next.
// After reset both stores are swept to zero, one entry per cycle over the
// entries 0 to max(HOLD_DEPTH, INPUT_DEPTH) - 1; requests are held off
// during that sweep but configuration writes are taken. Registers reset to
// slave id 1, counts 256 and input base 0.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave #(
    parameter int HOLD_DEPTH   = 256,
    parameter int INPUT_DEPTH  = 256,
    parameter int MAX_QUANTITY = 125
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  reg_index,
    input  logic [15:0] reg_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] tx_data,
    output logic [2:0]  tx_bytes,
    output logic        tx_last
);
    import mrs_pkg::*;

    localparam int HAW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int IAW = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int MAXD = (HOLD_DEPTH > INPUT_DEPTH) ? HOLD_DEPTH : INPUT_DEPTH;
    localparam int CAW = $clog2(MAXD + 1);

    // Configuration registers.
    logic [7:0]  slave_id_reg;
    logic [8:0]  holding_count_reg;
    logic [8:0]  input_count_reg;
    logic [15:0] input_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_id_reg      <= 8'd1;
            holding_count_reg <= 9'd256;
            input_count_reg   <= 9'd256;
            input_base_reg    <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                2'(REG_SLAVE_ID):      slave_id_reg      <= cfg_data[7:0];
                2'(REG_HOLDING_COUNT): holding_count_reg <= cfg_data[8:0];
                2'(REG_INPUT_COUNT):   input_count_reg   <= cfg_data[8:0];
                default:               input_base_reg    <= cfg_data;
            endcase
        end
    end

    // Frame receive state and reply sequencer registers.
    state_t      state_reg, state_next;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  flen_reg;
    logic [15:0] rcrc_reg;
    logic        recv_reg;
    logic [CAW-1:0] clr_reg;
    logic        fc4_reg;
    logic        exc_reg;
    logic [7:0]  exc_code_reg;
    logic [16:0] start_reg;
    logic [6:0]  qty_reg, qty_next;
    logic [6:0]  idx_reg;
    logic [15:0] tcrc_reg;
    logic [31:0] acc_reg;
    logic [2:0]  acnt_reg;
    logic        last_pending_reg;
    logic [7:0]  crc_hi_reg;
    logic        out_valid_reg;
    logic [31:0] tx_data_reg;
    logic [2:0]  tx_bytes_reg;
    logic        tx_last_reg;

    logic accept;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Stores.
    logic          h_we, i_we;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [IAW-1:0] i_waddr, i_raddr;
    logic [15:0]   h_wdata, i_wdata, h_rdata, i_rdata;
    logic          clearing;
    logic [16:0]   rd_addr;

    assign clearing = (state_reg == ST_CLEAR);
    assign rd_addr  = start_reg + {10'd0, idx_reg};

    always_comb
    begin
        h_we    = 1'b0;
        i_we    = 1'b0;
        h_waddr = HAW'(reg_index);
        i_waddr = IAW'(reg_index);
        h_wdata = reg_value;
        i_wdata = reg_value;
        if (clearing)
        begin
            h_we    = (17'(clr_reg) < 17'(HOLD_DEPTH));
            i_we    = (17'(clr_reg) < 17'(INPUT_DEPTH));
            h_waddr = clr_reg[HAW-1:0];
            i_waddr = clr_reg[IAW-1:0];
            h_wdata = 16'd0;
            i_wdata = 16'd0;
        end
        else if (accept)
        begin
            h_we = (action == ACT_WHOLD) && (17'(reg_index) < 17'(HOLD_DEPTH));
            i_we = (action == ACT_WINP) && (17'(reg_index) < 17'(INPUT_DEPTH));
        end
        h_raddr = rd_addr[HAW-1:0];
        i_raddr = rd_addr[IAW-1:0];
    end

    mrs_store #(.DEPTH(HOLD_DEPTH), .AW(HAW)) u_hold (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    mrs_store #(.DEPTH(INPUT_DEPTH), .AW(IAW)) u_inp (
        .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .raddr(i_raddr), .rdata(i_rdata)
    );

    // Judgement values from the header.
    logic [15:0] addr_w, qty_w;
    logic        fc_ok, fc4_w, frame_ok;
    logic [16:0] lim_w;
    logic [16:0] start_w;
    logic [17:0] end_w;
    logic        exc_w;
    logic [7:0]  exc_code_w;

    always_comb
    begin
        addr_w   = {hdr_reg[2], hdr_reg[3]};
        qty_w    = {hdr_reg[4], hdr_reg[5]};
        fc4_w    = (hdr_reg[1] == FC_INPUT);
        fc_ok    = (hdr_reg[1] == FC_HOLDING) || fc4_w;
        frame_ok = recv_reg && (flen_reg >= 8'd8) && (rcrc_reg == 16'd0)
                   && (hdr_reg[0] == slave_id_reg) && fc_ok;
        if (fc4_w)
            lim_w = (17'(input_count_reg) > 17'(INPUT_DEPTH)) ?
                    17'(INPUT_DEPTH) : 17'(input_count_reg);
        else
            lim_w = (17'(holding_count_reg) > 17'(HOLD_DEPTH)) ?
                    17'(HOLD_DEPTH) : 17'(holding_count_reg);
        start_w    = fc4_w ? ({1'b0, addr_w} - {1'b0, input_base_reg}) : {1'b0, addr_w};
        end_w      = {1'b0, start_w} + {2'b0, qty_w};
        exc_w      = 1'b0;
        exc_code_w = EXC_RANGE;
        if (qty_w == 16'd0 || qty_w > 16'(MAX_QUANTITY))
        begin
            exc_w      = 1'b1;
            exc_code_w = EXC_QTY;
        end
        else if (fc4_w && addr_w < input_base_reg)
            exc_w = 1'b1;
        else if (end_w > {1'b0, lim_w})
            exc_w = 1'b1;
    end

    // Byte packer: unless stalled, one byte per cycle goes into a group.
    logic        push;
    logic [7:0]  push_byte;
    logic        push_crc;
    logic        push_final;
    logic        grp_full;
    logic [31:0] acc_new;

    assign acc_new  = acc_reg | ({push_byte, 24'd0} >> {acnt_reg[1:0], 3'd0});
    assign grp_full = (acnt_reg == 3'd3) || push_final;

    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        push_byte  = 8'd0;
        push_crc   = 1'b1;
        push_final = 1'b0;
        qty_next   = qty_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (17'(clr_reg) == 17'(MAXD - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept && action == ACT_END)
                    state_next = ST_JUDGE;
            ST_JUDGE:
            begin
                state_next = frame_ok ? ST_HDR : ST_IDLE;
                qty_next   = qty_w[6:0];
            end
            ST_HDR:
                if (!out_valid_reg || !out_stall || acnt_reg != 3'd3)
                begin
                    push = 1'b1;
                    unique case (idx_reg[1:0])
                        2'd0:    push_byte = slave_id_reg;
                        2'd1:    push_byte = exc_reg ? (EXC_FLAG | (fc4_reg ? FC_INPUT
                                              : FC_HOLDING)) : (fc4_reg ? FC_INPUT
                                              : FC_HOLDING);
                        default: push_byte = exc_reg ? exc_code_reg : {qty_reg, 1'b0};
                    endcase
                    if (idx_reg[1:0] == 2'd2)
                        state_next = exc_reg ? ST_CRC : ST_RDREQ;
                end
            ST_RDREQ:
                state_next = ST_RDWAIT;
            ST_RDWAIT:
                state_next = ST_DATA;
            ST_DATA:
                if (!out_valid_reg || !out_stall || acnt_reg != 3'd3)
                begin
                    push      = 1'b1;
                    push_byte = last_pending_reg ? crc_hi_reg
                              : (fc4_reg ? i_rdata[15:8] : h_rdata[15:8]);
                    if (last_pending_reg)
                    begin
                        qty_next   = qty_reg - 7'd1;
                        state_next = (qty_reg == 7'd1) ? ST_CRC : ST_RDREQ;
                    end
                end
            ST_CRC:
                // The final CRC byte always closes a group, so it must wait
                // for the output register to be free.
                if (!out_valid_reg || !out_stall
                    || (acnt_reg != 3'd3 && !last_pending_reg))
                begin
                    push       = 1'b1;
                    push_crc   = 1'b0;
                    push_byte  = last_pending_reg ? tcrc_reg[15:8] : tcrc_reg[7:0];
                    push_final = last_pending_reg;
                    if (last_pending_reg)
                        state_next = ST_EMIT;
                end
            ST_EMIT:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // In ST_DATA the low byte of the word is held in crc_hi_reg and sent on
    // the second pass; last_pending_reg tells the two halves apart.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            recv_reg         <= 1'b0;
            flen_reg         <= 8'd0;
            rcrc_reg         <= CRC_INIT;
            out_valid_reg    <= 1'b0;
            acnt_reg         <= 3'd0;
            last_pending_reg <= 1'b0;
            idx_reg          <= 7'd0;
            qty_reg          <= 7'd0;
            for (int k = 0; k < 6; k++)
                hdr_reg[k] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            qty_reg   <= qty_next;
            if (clearing)
                clr_reg <= clr_reg + CAW'(1);
            if (out_valid_reg && !out_stall && !(push && grp_full))
                out_valid_reg <= 1'b0;
            if (accept && action == ACT_BYTE)
            begin
                if (flen_reg < 8'd6)
                    hdr_reg[flen_reg[2:0]] <= rx_byte;
                if (flen_reg != 8'd255)
                    flen_reg <= flen_reg + 8'd1;
                rcrc_reg <= crc_feed(rcrc_reg, rx_byte);
                recv_reg <= 1'b1;
            end
            if (state_reg == ST_JUDGE)
            begin
                recv_reg         <= 1'b0;
                flen_reg         <= 8'd0;
                rcrc_reg         <= CRC_INIT;
                fc4_reg          <= fc4_w;
                exc_reg          <= exc_w;
                exc_code_reg     <= exc_code_w;
                start_reg        <= start_w;
                idx_reg          <= 7'd0;
                tcrc_reg         <= CRC_INIT;
                acc_reg          <= 32'd0;
                acnt_reg         <= 3'd0;
                last_pending_reg <= 1'b0;
            end
            if (state_reg == ST_HDR && push)
                idx_reg <= (idx_reg[1:0] == 2'd2) ? 7'd0 : idx_reg + 7'd1;
            if (state_reg == ST_DATA && push)
            begin
                if (!last_pending_reg)
                    crc_hi_reg <= fc4_reg ? i_rdata[7:0] : h_rdata[7:0];
                else
                    idx_reg <= idx_reg + 7'd1;
                last_pending_reg <= !last_pending_reg;
            end
            if (state_reg == ST_CRC && push)
                last_pending_reg <= !last_pending_reg;
            if (push)
            begin
                if (push_crc)
                    tcrc_reg <= crc_feed(tcrc_reg, push_byte);
                if (grp_full)
                begin
                    out_valid_reg <= 1'b1;
                    tx_data_reg   <= acc_new;
                    tx_bytes_reg  <= acnt_reg + 3'd1;
                    tx_last_reg   <= push_final;
                    acc_reg       <= 32'd0;
                    acnt_reg      <= 3'd0;
                end
                else
                begin
                    acc_reg  <= acc_new;
                    acnt_reg <= acnt_reg + 3'd1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_data   = tx_data_reg;
    assign tx_bytes  = tx_bytes_reg;
    assign tx_last   = tx_last_reg;

    // A group is only overwritten after the previous one has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("output group lost");
    // Requests are never taken while a reply is built.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !accept)
        else $error("request accepted while busy");
    // The byte count of a group stays within one to four.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (tx_bytes_reg != 3'd0 && tx_bytes_reg <= 3'd4))
        else $error("bad group size");
endmodule
